FILE: rtl/lnft_pkg.sv
// Shared types, constants and table lookups for the lightning noise floor tracker.
// No dependencies; imported by every module of the block.
package lnft_pkg;

  localparam int LNFT_HISTORY_DEPTH = 8;
  localparam int TIME_W   = 32;
  localparam int ENERGY_W = 21;
  localparam int DIST_W   = 6;
  localparam int LEVEL_W  = 3;
  localparam int FLOOR_W  = 11;
  localparam int COUNT_W  = 16;
  localparam int RIDX_W   = 3;
  localparam int READ_SPAN_MAX = 8;

  localparam logic [TIME_W-1:0]  HOLDOFF_RESET = 32'd60000;
  localparam logic [TIME_W-1:0]  REDUCE_RESET  = 32'd600000;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

  localparam int IRQ_NOISE     = 0;
  localparam int IRQ_DISTURBER = 2;
  localparam int IRQ_LIGHTNING = 3;

  typedef enum logic [1:0] {
    CMD_POLL     = 2'd0,
    CMD_POLL_IRQ = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } lnft_cmd_t;

  typedef enum logic [1:0] {
    CFG_OUTDOOR = 2'd0,
    CFG_HOLDOFF = 2'd1,
    CFG_REDUCE  = 2'd2
  } lnft_cfg_idx_t;

  // raise balance, two's complement, kept in -1..1
  localparam logic [1:0] BAL_NEG  = 2'b11;
  localparam logic [1:0] BAL_ZERO = 2'b00;
  localparam logic [1:0] BAL_POS  = 2'b01;

  typedef struct packed {
    logic [TIME_W-1:0]   stamp;
    logic [ENERGY_W-1:0] energy;
    logic [DIST_W-1:0]   distance;
  } lnft_strike_t;

  typedef struct packed {
    logic              take;
    logic              poll;
    logic              poll_irq;
    logic              noise_hit;
    logic [TIME_W-1:0] now;
  } lnft_poll_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               out_of_range;
  } lnft_level_t;

  typedef struct packed {
    logic                changed;
    logic [LEVEL_W-1:0]  noise_level;
    logic [FLOOR_W-1:0]  noise_floor_value;
    logic                level_out_of_range;
    logic [COUNT_W-1:0]  disturber_total;
    logic [TIME_W-1:0]   last_disturber_ms;
    logic                hist_valid;
    logic [TIME_W-1:0]   hist_time;
    logic [ENERGY_W-1:0] hist_energy;
    logic [DIST_W-1:0]   hist_distance;
  } lnft_result_t;

  function automatic logic [FLOOR_W-1:0] lnft_floor(input logic [LEVEL_W-1:0] level,
                                                    input logic outdoor);
    logic [FLOOR_W-1:0] v;
    v = '0;
    if (outdoor) begin
      case (level)
        3'd0: v = 11'd390;
        3'd1: v = 11'd630;
        3'd2: v = 11'd860;
        3'd3: v = 11'd1100;
        3'd4: v = 11'd1140;
        3'd5: v = 11'd1570;
        3'd6: v = 11'd1800;
        default: v = 11'd2000;
      endcase
    end else begin
      case (level)
        3'd0: v = 11'd28;
        3'd1: v = 11'd45;
        3'd2: v = 11'd62;
        3'd3: v = 11'd78;
        3'd4: v = 11'd95;
        3'd5: v = 11'd112;
        3'd6: v = 11'd130;
        default: v = 11'd146;
      endcase
    end
    return v;
  endfunction

endpackage

FILE: rtl/lnft_cell.sv
// One history cell: holds a strike record and hands it to the next cell on a push.
// Depends on lnft_pkg.
module lnft_cell
  import lnft_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         clr,
  input  lnft_strike_t prev,
  output lnft_strike_t held
);

  logic [TIME_W-1:0]   stamp;
  logic [ENERGY_W-1:0] energy;
  logic [DIST_W-1:0]   distance;

  // zero time marks an empty entry
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
    end else if (clr) begin
      stamp <= '0;
    end else if (shift) begin
      stamp <= prev.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      energy   <= prev.energy;
      distance <= prev.distance;
    end
  end

  assign held = '{stamp: stamp, energy: energy, distance: distance};

endmodule

FILE: rtl/lnft_level.sv
// Noise floor level tracker: raise hysteresis, holdoff and reduction timers.
// Depends on lnft_pkg.
module lnft_level
  import lnft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lnft_poll_t        poll,
  input  logic [TIME_W-1:0] holdoff,
  input  logic [TIME_W-1:0] reduce,
  output lnft_level_t       cur,
  output lnft_level_t       nxt,
  output logic              bump
);

  logic [LEVEL_W-1:0] level, level_next;
  logic               range_flag, range_flag_next;
  logic [1:0]         balance, balance_next;
  logic [TIME_W-1:0]  last_change, last_raise;
  logic [TIME_W-1:0]  since_raise, since_change;
  logic               raise_ok, reduce_ok;

  assign since_raise  = poll.now - last_raise;
  assign since_change = poll.now - last_change;

  // a raise stamps last_change with now; the !raise_ok term rules out a reduction in the same beat
  assign raise_ok  = poll.take && poll.poll_irq && poll.noise_hit && (since_raise > holdoff);
  assign reduce_ok = poll.take && poll.poll && !raise_ok && (since_change > reduce);

  always_comb begin
    level_next      = level;
    range_flag_next = range_flag;
    balance_next    = balance;
    bump            = 1'b0;
    if (raise_ok) begin
      if (balance == BAL_POS) begin
        bump = 1'b1;
        if (level != LEVEL_MAX) begin
          level_next      = level + 3'd1;
          range_flag_next = 1'b0;
        end else begin
          range_flag_next = 1'b1;
        end
      end else begin
        balance_next = balance + 2'd1;
      end
    end
    if (reduce_ok) begin
      if (balance == BAL_NEG) begin
        bump = 1'b1;
        if (range_flag) begin
          range_flag_next = 1'b0;
        end else if (level != '0) begin
          level_next = level - 3'd1;
        end
      end else begin
        balance_next = balance - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= LEVEL_RESET;
      range_flag  <= 1'b0;
      balance     <= BAL_ZERO;
      last_change <= '0;
      last_raise  <= '0;
    end else if (poll.take) begin
      level      <= level_next;
      range_flag <= range_flag_next;
      balance    <= balance_next;
      if (raise_ok) begin
        last_raise  <= poll.now;
        last_change <= poll.now;
      end else if (reduce_ok) begin
        last_change <= poll.now;
      end
    end
  end

  assign cur = '{level: level, out_of_range: range_flag};
  assign nxt = '{level: level_next, out_of_range: range_flag_next};

endmodule

FILE: rtl/lnft_out_buf.sv
// Two-entry result register: output stage plus skid stage.
// Depends on lnft_pkg.
module lnft_out_buf
  import lnft_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         room,
  input  lnft_result_t d,
  output logic         q_valid,
  input  logic         q_ready,
  output lnft_result_t q
);

  logic         skid_valid;
  lnft_result_t skid;
  logic         pop;

  assign room = !skid_valid;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      q_valid    <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (!q_valid) begin
      q_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q <= skid_valid ? skid : d;
    end else if (!q_valid) begin
      q <= d;
    end else if (push) begin
      skid <= d;
    end
  end

endmodule

FILE: rtl/lightning_noise_floor_tracker_unit.sv
// Top level of the lightning noise floor tracker: config registers, disturber record,
// strike history cell row and result buffer. Depends on lnft_pkg and all lnft_* modules.
// One beat is accepted per clock cycle and its result is registered in the output stage,
// or in the skid stage while an earlier result waits; the two-entry buffer keeps input
// beats flowing while a result waits, and in_ready drops only when both entries are full.
// All state updates complete in the accept cycle, and the strike history is a row of
// HISTORY_DEPTH cells that all shift on the same edge. The config port is always ready.
module lightning_noise_floor_tracker_unit
  import lnft_pkg::*;
#(
  parameter int HISTORY_DEPTH = LNFT_HISTORY_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [3:0]          irq_bits,
  input  logic [ENERGY_W-1:0] strike_energy,
  input  logic [DIST_W-1:0]   strike_distance,
  input  logic [RIDX_W-1:0]   read_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                changed,
  output logic [LEVEL_W-1:0]  noise_level,
  output logic [FLOOR_W-1:0]  noise_floor_value,
  output logic                level_out_of_range,
  output logic [COUNT_W-1:0]  disturber_total,
  output logic [TIME_W-1:0]   last_disturber_ms,
  output logic                hist_valid,
  output logic [TIME_W-1:0]   hist_time,
  output logic [ENERGY_W-1:0] hist_energy,
  output logic [DIST_W-1:0]   hist_distance,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int READ_SPAN = (HISTORY_DEPTH < READ_SPAN_MAX) ? HISTORY_DEPTH : READ_SPAN_MAX;

  logic              outdoor_mode;
  logic [TIME_W-1:0] raise_holdoff_ms;
  logic [TIME_W-1:0] reduce_interval_ms;

  lnft_cmd_t    cmd_c;
  logic         accept, is_poll, is_poll_irq, is_read, is_clear;
  logic         dist_hit, light_hit, push, clr;
  lnft_poll_t   poll;
  lnft_level_t  lvl_cur, lvl_next;
  logic         lvl_bump;

  logic [COUNT_W-1:0] dist_count, dist_count_next;
  logic [TIME_W-1:0]  dist_time, dist_time_next;

  lnft_strike_t cells [HISTORY_DEPTH];
  lnft_strike_t head;
  lnft_strike_t rd;
  logic         rd_hit;

  lnft_result_t res, res_q;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outdoor_mode       <= 1'b0;
      raise_holdoff_ms   <= HOLDOFF_RESET;
      reduce_interval_ms <= REDUCE_RESET;
    end else if (cfg_valid) begin
      unique case (lnft_cfg_idx_t'(cfg_index))
        CFG_OUTDOOR: outdoor_mode       <= cfg_data[0];
        CFG_HOLDOFF: raise_holdoff_ms   <= cfg_data;
        CFG_REDUCE:  reduce_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // command decode
  assign cmd_c       = lnft_cmd_t'(cmd);
  assign accept      = in_valid && in_ready;
  assign is_poll_irq = (cmd_c == CMD_POLL_IRQ);
  assign is_poll     = (cmd_c == CMD_POLL) || is_poll_irq;
  assign is_read     = (cmd_c == CMD_READ);
  assign is_clear    = (cmd_c == CMD_CLEAR);
  assign dist_hit    = is_poll_irq && irq_bits[IRQ_DISTURBER];
  assign light_hit   = is_poll_irq && irq_bits[IRQ_LIGHTNING];
  assign push        = accept && light_hit;
  assign clr         = accept && is_clear;

  assign poll = '{take: accept, poll: is_poll, poll_irq: is_poll_irq,
                  noise_hit: irq_bits[IRQ_NOISE], now: now_ms};

  lnft_level u_level (
    .clk     (clk),
    .rst     (rst),
    .poll    (poll),
    .holdoff (raise_holdoff_ms),
    .reduce  (reduce_interval_ms),
    .cur     (lvl_cur),
    .nxt     (lvl_next),
    .bump    (lvl_bump)
  );

  // disturber record
  always_comb begin
    dist_count_next = dist_count;
    dist_time_next  = dist_time;
    if (is_clear) begin
      dist_count_next = '0;
      dist_time_next  = '0;
    end else if (dist_hit) begin
      dist_time_next = now_ms;
      if (dist_count != COUNT_MAX) begin
        dist_count_next = dist_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_count <= '0;
      dist_time  <= '0;
    end else if (accept) begin
      dist_count <= dist_count_next;
      dist_time  <= dist_time_next;
    end
  end

  // strike history row
  assign head = '{stamp: now_ms, energy: strike_energy, distance: strike_distance};

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    lnft_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (push),
      .clr   (clr),
      .prev  ((g == 0) ? head : cells[(g == 0) ? 0 : g - 1]),
      .held  (cells[g])
    );
  end

  always_comb begin
    rd     = '0;
    rd_hit = 1'b0;
    for (int k = 0; k < READ_SPAN; k++) begin
      if (read_index == RIDX_W'(k)) begin
        rd     = cells[k];
        rd_hit = (cells[k].stamp != '0);
      end
    end
  end

  // result
  always_comb begin
    res.changed            = is_poll && (lvl_bump || dist_hit || light_hit);
    res.noise_level        = lvl_next.level;
    res.noise_floor_value  = lnft_floor(lvl_next.level, outdoor_mode);
    res.level_out_of_range = lvl_next.out_of_range;
    res.disturber_total    = dist_count_next;
    res.last_disturber_ms  = dist_time_next;
    res.hist_valid         = 1'b0;
    res.hist_time          = '0;
    res.hist_energy        = '0;
    res.hist_distance      = '0;
    if (is_read && rd_hit) begin
      res.hist_valid    = 1'b1;
      res.hist_time     = rd.stamp;
      res.hist_energy   = rd.energy;
      res.hist_distance = rd.distance;
    end
  end

  lnft_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .room    (in_ready),
    .d       (res),
    .q_valid (out_valid),
    .q_ready (out_ready),
    .q       (res_q)
  );

  assign changed            = res_q.changed;
  assign noise_level        = res_q.noise_level;
  assign noise_floor_value  = res_q.noise_floor_value;
  assign level_out_of_range = res_q.level_out_of_range;
  assign disturber_total    = res_q.disturber_total;
  assign last_disturber_ms  = res_q.last_disturber_ms;
  assign hist_valid         = res_q.hist_valid;
  assign hist_time          = res_q.hist_time;
  assign hist_energy        = res_q.hist_energy;
  assign hist_distance      = res_q.hist_distance;

`ifndef NO_ASSERTIONS
  a_range_at_top: assert property (@(posedge clk) disable iff (rst)
    lvl_cur.out_of_range |-> (lvl_cur.level == LEVEL_MAX))
    else $error("out-of-range flag set below the top level");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clr |=> (cells[0].stamp == '0) && (dist_count == '0) && (dist_time == '0))
    else $error("clear beat left detection record");

  a_count_monotone: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_clear) |=> (dist_count >= $past(dist_count)))
    else $error("disturber count dropped without clear");

  a_hist_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hist_valid) |-> (hist_time == '0) && (hist_energy == '0))
    else $error("history fields nonzero without a valid entry");
`endif

endmodule
